### rtl/core/dictionary_key_offset_scanner_assert.svh
// assertion macros used by the scanner controller rtl
// both expect clk_i and rst_ni in scope
`ifndef DICTIONARY_KEY_OFFSET_SCANNER_ASSERT_SVH
`define DICTIONARY_KEY_OFFSET_SCANNER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DKOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define DKOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dkos_pkg.sv
// ----------------------------------------------------------------------------
// dkos_pkg
// Sizes, byte codes and controller/datapath types of the key offset scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dkos_pkg;

  localparam int unsigned TOKEN_LIMIT   = 40;
  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned MAX_RESULTS   = 20;
  localparam int unsigned OFFSET_W      = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TAG_W         = 7;
  // length counter holds up to TOKEN_LIMIT-1, also the buffer address
  localparam int unsigned LEN_W         = $clog2(TOKEN_LIMIT);
  // walk index may step up to three past the last byte
  localparam int unsigned IDX_W         = $clog2(TOKEN_LIMIT + 3);
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [BYTE_W-1:0] JIS3_LEAD = 8'h8f;
  localparam logic [BYTE_W-1:0] KANJI_MIN = 8'hb0;
  localparam logic [BYTE_W-1:0] DEL_CHAR  = 8'd127;
  localparam logic [BYTE_W-1:0] DIGIT_MAX = 8'h39;
  localparam logic [BYTE_W-1:0] HIGH_BIT  = 8'h80;
  localparam logic [TAG_W-1:0]  TAG_RESET = 7'h40;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_NEXT,
    SEL_WALK
  } cand_sel_e;

  typedef struct packed {
    logic      accept;
    logic      cand;
    cand_sel_e sel;
    logic      walk_init;
    logic      rd_en;
    logic      step;
    logic      flush;
  } dkos_cmd_t;

  typedef struct packed {
    logic end_latin;
    logic end_jp;
    logic tag_lead;
    logic can_push;
    logic walk_more;
    logic walk_hit;
  } dkos_sts_t;

endpackage

### rtl/core/dkos_in_if.sv
// ----------------------------------------------------------------------------
// dkos_in_if
// Byte stream channel into the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dkos_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       new_stream;

  modport source (output valid, output text_byte, output new_stream, input ready);
  modport sink   (input valid, input text_byte, input new_stream, output ready);
endinterface

### rtl/core/dkos_out_if.sv
// ----------------------------------------------------------------------------
// dkos_out_if
// Key offset channel out of the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dkos_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_offset;
  logic        last_of_run;

  modport source (output valid, output key_offset, output last_of_run, input ready);
  modport sink   (input valid, input key_offset, input last_of_run, output ready);
endinterface

### rtl/core/dkos_datapath.sv
// ----------------------------------------------------------------------------
// dkos_datapath
// Token tracking, token buffer, walk index and offset output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkos_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dkos_pkg::TAG_W-1:0]    cfg_wdata_i,
  input  logic [dkos_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                          new_stream_i,
  input  dkos_pkg::dkos_cmd_t           cmd_i,
  output dkos_pkg::dkos_sts_t           sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [dkos_pkg::OFFSET_W-1:0] key_offset_o,
  output logic                          last_of_run_o
);
  import dkos_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
    logic upper, lower, digit;
    upper = (c >= "A") && (c <= "Z");
    lower = (c >= "a") && (c <= "z");
    digit = (c >= "0") && (c <= DIGIT_MAX);
    return upper || lower || digit || ((c & HIGH_BIT) != '0);
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_add(input logic [POSITION_BITS-1:0] a,
                                                       input logic [IDX_W-1:0] k);
    logic [POSITION_BITS:0] s;
    s = {1'b0, a} + (POSITION_BITS + 1)'(k);
    return s[POSITION_BITS] ? POS_MAX : s[POSITION_BITS-1:0];
  endfunction

  logic [TAG_W-1:0]         tag_q;
  logic                     in_token_q;
  logic [LEN_W-1:0]         len_q;
  logic [POSITION_BITS-1:0] start_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [BYTE_W-1:0]        c0_q;
  logic [BYTE_W-1:0]        c1_q;
  logic [LEN_W-1:0]         wlen_q;
  logic [IDX_W-1:0]         idx_q;
  logic [BYTE_W-1:0]        rdata_q;
  logic [BYTE_W-1:0]        mem [TOKEN_LIMIT];
  logic                     pend_valid_q;
  logic [POSITION_BITS-1:0] pend_q;
  logic                     out_valid_q;
  logic [POSITION_BITS-1:0] out_off_q;
  logic                     out_last_q;
  logic [CNT_W-1:0]         cnt_q;

  logic                     in_tok_eff;
  logic [POSITION_BITS-1:0] pos_eff;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     cont_char;
  logic                     start_char;
  logic                     tok_end;
  logic                     tok_cont;
  logic                     tok_start;
  logic                     latin_ok;
  logic                     walk_hit;
  logic                     cand_live;
  logic                     push_out;
  logic [LEN_W-1:0]         wr_addr;
  logic [POSITION_BITS-1:0] cand_val;

  // a new stream drops the open token before this byte is looked at
  assign in_tok_eff = in_token_q & ~new_stream_i;
  assign pos_eff    = new_stream_i ? POSITION_BITS'(1) : pos_q;
  assign pos_inc    = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + POSITION_BITS'(1);
  assign cont_char  = is_word_char(text_byte_i) || (text_byte_i == "-") ||
                      (text_byte_i == ".");
  assign start_char = is_word_char(text_byte_i) || (text_byte_i == {1'b0, tag_q});
  assign tok_end    = in_tok_eff && !cont_char;
  assign tok_cont   = in_tok_eff && cont_char;
  assign tok_start  = !in_tok_eff && start_char;
  // a one-byte latin token never counts, a two-byte one only when its second byte is a digit or below
  assign latin_ok   = (c0_q < DEL_CHAR) &&
                      ((len_q >= LEN_W'(3)) || ((len_q == LEN_W'(2)) && (c1_q <= DIGIT_MAX)));
  assign walk_hit   = (rdata_q >= KANJI_MIN) || (rdata_q == JIS3_LEAD);
  assign wr_addr    = tok_start ? '0 : len_q;

  always_comb begin
    case (cmd_i.sel)
      SEL_START: cand_val = start_q;
      SEL_NEXT:  cand_val = sat_add(start_q, IDX_W'(1));
      SEL_WALK:  cand_val = sat_add(start_q, idx_q);
      default:   cand_val = start_q;
    endcase
  end

  assign cand_live = cmd_i.cand && ((cmd_i.sel != SEL_WALK) || walk_hit) &&
                     (cnt_q < CNT_W'(MAX_RESULTS));
  // the held offset goes out once we know whether another one follows
  assign push_out  = (cmd_i.flush || cand_live) && pend_valid_q;

  assign sts_o.end_latin = tok_end && latin_ok;
  assign sts_o.end_jp    = tok_end && (c0_q > DEL_CHAR);
  assign sts_o.tag_lead  = (c0_q == {1'b0, tag_q});
  assign sts_o.can_push  = !pend_valid_q || !out_valid_q || out_ready_i;
  assign sts_o.walk_more = idx_q < IDX_W'(wlen_q);
  assign sts_o.walk_hit  = walk_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q        <= TAG_RESET;
      in_token_q   <= 1'b0;
      len_q        <= '0;
      start_q      <= '0;
      pos_q        <= POSITION_BITS'(1);
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        tag_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        pos_q <= pos_inc;
        if (tok_cont) begin
          if (len_q < LEN_W'(TOKEN_LIMIT - 1)) begin
            len_q <= len_q + LEN_W'(1);
          end
        end else if (tok_start) begin
          in_token_q <= 1'b1;
          start_q    <= pos_eff;
          len_q      <= LEN_W'(1);
        end else begin
          in_token_q <= 1'b0;
          len_q      <= '0;
        end
      end
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        cnt_q        <= '0;
      end else if (cand_live) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && tok_start) begin
      c0_q <= text_byte_i;
    end
    if (cmd_i.accept && tok_cont && (len_q == LEN_W'(1))) begin
      c1_q <= text_byte_i;
    end
    if (cmd_i.accept && tok_end) begin
      wlen_q <= len_q;
    end
    if (cmd_i.walk_init) begin
      idx_q <= (c0_q == JIS3_LEAD) ? IDX_W'(3) : IDX_W'(2);
    end else if (cmd_i.step) begin
      idx_q <= idx_q + ((rdata_q == JIS3_LEAD) ? IDX_W'(3) : IDX_W'(2));
    end
    if (cand_live) begin
      pend_q <= cand_val;
    end
    if (push_out) begin
      out_off_q  <= pend_q;
      out_last_q <= cmd_i.flush;
    end
  end

  // token buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (tok_start || tok_cont)) begin
      mem[wr_addr] <= text_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q[LEN_W-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_offset_o  = OFFSET_W'(out_off_q);
  assign last_of_run_o = out_last_q;

endmodule

### rtl/core/dkos_ctrl.sv
// ----------------------------------------------------------------------------
// dkos_ctrl
// Sequencer: takes bytes and steps through the offsets of an ended token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dictionary_key_offset_scanner_assert.svh"

module dkos_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dkos_pkg::dkos_sts_t sts_i,
  output dkos_pkg::dkos_cmd_t cmd_o
);
  import dkos_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAT0,
    ST_LAT1,
    ST_JP0,
    ST_RD,
    ST_EV,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_START;
    cmd_o.accept  = ready_q && in_valid_i;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          if (sts_i.end_jp) begin
            state_d = ST_JP0;
          end else if (sts_i.end_latin) begin
            state_d = ST_LAT0;
          end
        end
      end
      ST_LAT0: begin
        if (sts_i.can_push) begin
          cmd_o.cand = 1'b1;
          state_d    = sts_i.tag_lead ? ST_LAT1 : ST_FLUSH;
        end
      end
      ST_LAT1: begin
        if (sts_i.can_push) begin
          cmd_o.cand = 1'b1;
          cmd_o.sel  = SEL_NEXT;
          state_d    = ST_FLUSH;
        end
      end
      ST_JP0: begin
        if (sts_i.can_push) begin
          cmd_o.cand      = 1'b1;
          cmd_o.walk_init = 1'b1;
          state_d         = ST_RD;
        end
      end
      ST_RD: begin
        if (sts_i.walk_more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_EV;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_EV: begin
        // a non-kanji byte gives nothing and needs no room at the output
        if (!sts_i.walk_hit || sts_i.can_push) begin
          cmd_o.cand = 1'b1;
          cmd_o.sel  = SEL_WALK;
          cmd_o.step = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (sts_i.can_push) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

  `DKOS_ASSERT_IMP(a_push_has_room, (cmd_o.cand && ((cmd_o.sel != SEL_WALK) || sts_i.walk_hit)) || cmd_o.flush, sts_i.can_push, "offset pushed without output room")
  `DKOS_ASSERT_IMP(a_read_in_token, cmd_o.rd_en, sts_i.walk_more, "buffer read past token end")
  `DKOS_ASSERT_NXT(a_read_then_eval, cmd_o.rd_en, state_q == ST_EV, "buffer read not followed by evaluation")
  `DKOS_ASSERT_IMP(a_ready_only_idle, in_ready_o, state_q == ST_IDLE, "byte taken while walking a token")

endmodule

### rtl/core/dictionary_key_offset_scanner.sv
// output: a token's first offset waits in the pending register until the next offset or
//   the flush (japanese: next kanji hit or walk end), then goes to the output register
// throughput: 1 byte a cycle inside a token; an ended latin token holds off input
//   via LAT0, LAT1 on a tag lead, FLUSH; a japanese token via JP0, a read and a decode per step
// the walk is bound by the single read port of the token buffer
// reset: asynchronous, tag byte 0x40, no open token, position 1; buffer needs no clearing
// ----------------------------------------------------------------------------
// dictionary_key_offset_scanner
// Scans an EUC dictionary byte stream and emits byte offsets of index keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dictionary_key_offset_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dkos_pkg::TAG_W-1:0] cfg_wdata_i,
  dkos_in_if.sink                    in_i,
  dkos_out_if.source                 out_o
);
  import dkos_pkg::*;

  dkos_cmd_t cmd;
  dkos_sts_t sts;

  dkos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dkos_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .text_byte_i   (in_i.text_byte),
    .new_stream_i  (in_i.new_stream),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .key_offset_o  (out_o.key_offset),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule
